// File: rtl/mdoic_pkg.sv
// shared constants, codes and pipeline record for the offset/index converter
// no dependencies
`default_nettype none
package mdoic_pkg;

  localparam int NUM_DIMS   = 4;
  localparam int COORD_BITS = 16;
  localparam int OFF_BITS   = 32;
  localparam int EXT_BITS   = COORD_BITS + 1;
  localparam int NUM_REGS   = 2 * NUM_DIMS;
  localparam int ADDR_BITS  = $clog2(NUM_REGS) + 2;
  localparam int DIV_STEPS  = OFF_BITS;
  localparam int DIV_STAGES = NUM_DIMS * DIV_STEPS;
  localparam int HOR_STAGES = NUM_DIMS - 1;

  localparam logic [OFF_BITS-1:0] SAT_OFF = '1;

  typedef enum logic [1:0] {
    OP_LEFT_OFFSET  = 2'd0,
    OP_RIGHT_OFFSET = 2'd1,
    OP_LEFT_INDEX   = 2'd2,
    OP_RIGHT_INDEX  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BAD_CFG = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                           op;
    logic                                 bad;
    logic                                 oor;
    logic                                 ones;
    logic [NUM_DIMS-1:0][COORD_BITS-1:0]  diff;
    logic [OFF_BITS-1:0]                  acc;
    logic [OFF_BITS-1:0]                  word;
    logic [COORD_BITS-1:0]                part;
    logic [NUM_DIMS-1:0][COORD_BITS-1:0]  coord;
  } pipe_t;

endpackage
`default_nettype wire

// File: rtl/multidim_offset_index_convert_top.sv
// coordinate <-> linear offset converter, top level
// depends on mdoic_pkg
//
// usage: one transaction in on in_valid/in_stall, one result out on
// out_valid/out_stall for every accepted transaction, in order.
// op selects left (column-major) or right (row-major) offset, or the
// inverse index operations; bounds are written over the apb port while idle.
// pipeline: an input register, three multiply-add stages for the offset, 128
// one-bit restoring divide steps, 32 per dimension, and the output register.
// throughput: one transaction per cycle while out_stall does not hold the
// pipeline; the divide chain is fully pipelined.
// reset clears all valid bits and the bounds to zero (a one-element box).
// while out_valid is high and out_stall is asserted the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
`default_nettype none
module multidim_offset_index_convert_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         op,
  input  wire logic signed [15:0]                 coord_in_0,
  input  wire logic signed [15:0]                 coord_in_1,
  input  wire logic signed [15:0]                 coord_in_2,
  input  wire logic signed [15:0]                 coord_in_3,
  input  wire logic [31:0]                        offset_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [31:0]                             offset_out,
  output logic signed [15:0]                      coord_out_0,
  output logic signed [15:0]                      coord_out_1,
  output logic signed [15:0]                      coord_out_2,
  output logic signed [15:0]                      coord_out_3,
  output logic [1:0]                              status,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mdoic_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import mdoic_pkg::*;

  logic signed [COORD_BITS-1:0] cfg_regs [NUM_REGS];
  logic signed [COORD_BITS-1:0] lo [NUM_DIMS];
  logic signed [COORD_BITS-1:0] hi [NUM_DIMS];
  logic [EXT_BITS-1:0]          ext [NUM_DIMS];
  logic                         cfg_bad;

  logic                         advance;
  pipe_t                        pre_q, pre_next;
  logic                         pre_valid;
  pipe_t                        hor_q [HOR_STAGES];
  pipe_t                        hor_next [HOR_STAGES];
  logic [HOR_STAGES-1:0]        hor_valid;
  pipe_t                        div_q [DIV_STAGES];
  pipe_t                        div_next [DIV_STAGES];
  logic [DIV_STAGES-1:0]        div_valid;

  logic [COORD_BITS-1:0]        cin [NUM_DIMS];
  pipe_t                        fin;
  logic [1:0]                   status_next;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {{(32-COORD_BITS){1'b0}}, cfg_regs[paddr[ADDR_BITS-1:2]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_regs[i] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      cfg_regs[paddr[ADDR_BITS-1:2]] <= pwdata[COORD_BITS-1:0];
    end
  end

  always_comb begin
    cfg_bad = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lo[d]  = cfg_regs[2*d];
      hi[d]  = cfg_regs[2*d+1];
      ext[d] = EXT_BITS'(({hi[d][COORD_BITS-1], hi[d]} - {lo[d][COORD_BITS-1], lo[d]})
               + (EXT_BITS)'(1));
      if (hi[d] < lo[d]) cfg_bad = 1'b1;
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // input stage: range check and coordinate differences
  assign cin[0] = coord_in_0;
  assign cin[1] = coord_in_1;
  assign cin[2] = coord_in_2;
  assign cin[3] = coord_in_3;

  always_comb begin
    pre_next      = '0;
    pre_next.op   = op;
    pre_next.bad  = cfg_bad;
    pre_next.word = offset_in;
    pre_next.ones = &offset_in;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if ($signed(cin[d]) < lo[d] || $signed(cin[d]) > hi[d]) pre_next.oor = 1'b1;
      pre_next.diff[d] = COORD_BITS'(cin[d] - lo[d]);
    end
    pre_next.acc = op[0] ? {{(OFF_BITS-COORD_BITS){1'b0}}, pre_next.diff[0]}
                         : {{(OFF_BITS-COORD_BITS){1'b0}}, pre_next.diff[NUM_DIMS-1]};
  end

  // horner stages: acc = acc * extent + diff, saturating
  always_comb begin
    pipe_t                          src;
    logic [1:0]                     dim;
    logic [OFF_BITS+EXT_BITS-1:0]   prod;
    logic [OFF_BITS+EXT_BITS:0]     sum;
    for (int j = 0; j < HOR_STAGES; j++) begin
      src  = (j == 0) ? pre_q : hor_q[(j == 0) ? 0 : j-1];
      dim  = src.op[0] ? 2'(j+1) : 2'(NUM_DIMS-2-j);
      prod = {{EXT_BITS{1'b0}}, src.acc} * {{OFF_BITS{1'b0}}, ext[dim]};
      sum  = {1'b0, prod} + {{(OFF_BITS+EXT_BITS+1-COORD_BITS){1'b0}}, src.diff[dim]};
      hor_next[j] = src;
      hor_next[j].acc = (sum > {{(EXT_BITS+1){1'b0}}, SAT_OFF}) ? SAT_OFF
                                                                : sum[OFF_BITS-1:0];
    end
  end

  // restoring divide, one quotient bit per stage, one extent per 32 stages
  always_comb begin
    pipe_t                  src;
    logic [1:0]             k;
    logic [COORD_BITS-1:0]  p;
    logic [EXT_BITS-1:0]    t;
    logic [EXT_BITS-1:0]    e;
    for (int s = 0; s < DIV_STAGES; s++) begin
      src = (s == 0) ? hor_q[HOR_STAGES-1] : div_q[(s == 0) ? 0 : s-1];
      k   = src.op[0] ? 2'(NUM_DIMS-1-(s / DIV_STEPS)) : 2'(s / DIV_STEPS);
      e   = ext[k];
      p   = ((s % DIV_STEPS) == 0) ? '0 : src.part;
      t   = {p, src.word[OFF_BITS-1]};
      div_next[s] = src;
      div_next[s].word = {src.word[OFF_BITS-2:0], 1'b0};
      if (t >= e) begin
        div_next[s].part    = COORD_BITS'(t - e);
        div_next[s].word[0] = 1'b1;
      end else begin
        div_next[s].part = t[COORD_BITS-1:0];
      end
      if ((s % DIV_STEPS) == DIV_STEPS-1) begin
        div_next[s].coord[k] = COORD_BITS'(lo[k] + div_next[s].part);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
      hor_valid <= '0;
      div_valid <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      pre_valid <= in_valid;
      hor_valid <= {hor_valid[HOR_STAGES-2:0], pre_valid};
      div_valid <= {div_valid[DIV_STAGES-2:0], hor_valid[HOR_STAGES-1]};
      out_valid <= div_valid[DIV_STAGES-1];
    end
  end

  // output formatting
  assign fin = div_q[DIV_STAGES-1];

  always_comb begin
    if (fin.bad) begin
      status_next = ST_BAD_CFG;
    end else if (fin.op[1] ? (fin.word != '0 || fin.ones) : fin.oor) begin
      status_next = ST_RANGE;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pre_q <= pre_next;
      for (int j = 0; j < HOR_STAGES; j++) hor_q[j] <= hor_next[j];
      for (int s = 0; s < DIV_STAGES; s++) div_q[s] <= div_next[s];
      status      <= status_next;
      offset_out  <= (status_next == ST_OK && !fin.op[1]) ? fin.acc : '0;
      coord_out_0 <= (status_next == ST_OK && fin.op[1]) ? fin.coord[0] : '0;
      coord_out_1 <= (status_next == ST_OK && fin.op[1]) ? fin.coord[1] : '0;
      coord_out_2 <= (status_next == ST_OK && fin.op[1]) ? fin.coord[2] : '0;
      coord_out_3 <= (status_next == ST_OK && fin.op[1]) ? fin.coord[3] : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mdoic_checker.sv
// port-level checks for the offset/index converter, bound to the top level
// depends on mdoic_pkg and multidim_offset_index_convert_top
`default_nettype none
module mdoic_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [31:0]        offset_out,
  input wire logic signed [15:0] coord_out_0,
  input wire logic signed [15:0] coord_out_1,
  input wire logic signed [15:0] coord_out_2,
  input wire logic signed [15:0] coord_out_3,
  input wire logic [1:0]         status
);
  import mdoic_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(offset_out) && $stable(status))
    else $error("stalled transaction changed");

  a_stall_path: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_RANGE || status == ST_BAD_CFG)
    else $error("illegal status");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> offset_out == '0 && coord_out_0 == '0 &&
      coord_out_1 == '0 && coord_out_2 == '0 && coord_out_3 == '0)
    else $error("error result carries data");

endmodule

bind multidim_offset_index_convert_top mdoic_checker u_mdoic_checker (.*);
`default_nettype wire

// File: tb/sv/tb_multidim_offset_index_convert_top.sv
// self-checking testbench for multidim_offset_index_convert_top
// depends on mdoic_pkg and the converter rtl; drives bounds over apb, checks every result
`timescale 1ns / 1ps
`default_nettype none
module tb_multidim_offset_index_convert_top;
  import mdoic_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0][15:0] coord;
    logic [31:0] offset;
  } req_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [3:0][15:0] coord;
    logic [1:0] status;
  } answer_t;

  localparam int LATENCY = 132;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic signed [15:0] coord_in_0 = '0, coord_in_1 = '0, coord_in_2 = '0, coord_in_3 = '0;
  logic [31:0] offset_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] offset_out;
  logic signed [15:0] coord_out_0, coord_out_1, coord_out_2, coord_out_3;
  logic [1:0] status;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multidim_offset_index_convert_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bound registers as seen by the converter
  logic signed [15:0] box_lo [NUM_DIMS];
  logic signed [15:0] box_hi [NUM_DIMS];

  req_t    pending_reqs[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      n_checked = 0;
  int      n_ok = 0, n_range = 0, n_bad = 0;
  longint  cycles = 0;
  bit      idle_on = 1'b1;
  int      hold_cycles = 0;

  function automatic answer_t convert(req_t r);
    answer_t a;
    longint lo[NUM_DIMS], ext[NUM_DIMS], c[NUM_DIMS];
    longint unsigned length, step, acc, rem, p;
    bit bad;
    int k;
    a = '0;
    length = 1;
    bad = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lo[d] = box_lo[d];
      if (box_hi[d] < box_lo[d]) begin
        bad = 1'b1;
        ext[d] = 1;
      end else begin
        ext[d] = longint'(box_hi[d]) - lo[d] + 1;
      end
      length = length * ext[d];
      if (length > 64'hFFFF_FFFF) length = 64'hFFFF_FFFF;
    end
    if (bad) begin
      a.status = ST_BAD_CFG;
      return a;
    end
    if (r.op == OP_LEFT_OFFSET || r.op == OP_RIGHT_OFFSET) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        c[d] = $signed(r.coord[d]);
        if (c[d] < lo[d] || c[d] >= lo[d] + ext[d]) begin
          a.status = ST_RANGE;
          return a;
        end
      end
      acc = 0;
      step = 1;
      for (int d = 0; d < NUM_DIMS; d++) begin
        k = (r.op == OP_LEFT_OFFSET) ? d : NUM_DIMS - 1 - d;
        p = step * longint'(c[k] - lo[k]);
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
        acc = acc + p;
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        step = step * ext[k];
        if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
      end
      a.offset = acc[31:0];
    end else begin
      rem = r.offset;
      if (rem >= length) begin
        a.status = ST_RANGE;
        return a;
      end
      for (int d = 0; d < NUM_DIMS; d++) begin
        k = (r.op == OP_LEFT_INDEX) ? d : NUM_DIMS - 1 - d;
        a.coord[k] = 16'(lo[k] + longint'(rem % ext[k]));
        rem = rem / ext[k];
      end
    end
    a.status = ST_OK;
    return a;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          expected_answers.push_back(convert(r));
          in_valid <= 1'b1;
          op <= r.op;
          coord_in_0 <= r.coord[0];
          coord_in_1 <= r.coord[1];
          coord_in_2 <= r.coord[2];
          coord_in_3 <= r.coord[3];
          offset_in <= r.offset;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  int out_gap = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      answer_t got, want;
      got = {offset_out, coord_out_3, coord_out_2, coord_out_1, coord_out_0, status};
      if (expected_answers.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_answers.pop_front();
        n_checked <= n_checked + 1;
        case (want.status)
          ST_OK: n_ok <= n_ok + 1;
          ST_RANGE: n_range <= n_range + 1;
          default: n_bad <= n_bad + 1;
        endcase
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected off=%h c=%h st=%0d, got off=%h c=%h st=%0d",
                     want.offset, want.coord, want.status,
                     got.offset, got.coord, got.status);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("[multidim_offset_index_convert_top] ERROR");
      $finish;
    end
  end

  task automatic write_bound(input int idx, input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_BITS'(4 * idx);
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx % 2 == 0) box_lo[idx / 2] = value;
    else box_hi[idx / 2] = value;
  endtask

  task automatic set_box(input logic [3:0][15:0] lo, input logic [3:0][15:0] hi);
    for (int d = 0; d < NUM_DIMS; d++) begin
      write_bound(2 * d, lo[d]);
      write_bound(2 * d + 1, hi[d]);
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord(int d, bit in_box);
    longint l, h;
    l = box_lo[d];
    h = box_hi[d];
    if (in_box && h >= l) return 16'($urandom_range(0, 31) == 0 ? h :
                                      l + longint'($urandom) % (h - l + 1));
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'($urandom_range(0, 1) ? l - 1 : h + 1);
  endfunction

  function automatic longint unsigned box_length();
    longint unsigned n = 1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (box_hi[d] >= box_lo[d]) n = n * (longint'(box_hi[d]) - box_lo[d] + 1);
      if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
    end
    return n;
  endfunction

  task automatic add_random(int n);
    req_t r;
    longint unsigned len;
    for (int i = 0; i < n; i++) begin
      r.op = 2'($urandom_range(0, 3));
      for (int d = 0; d < NUM_DIMS; d++) r.coord[d] = pick_coord(d, $urandom_range(0, 9) != 0);
      len = box_length();
      case ($urandom_range(0, 9))
        0: r.offset = $urandom;
        1: r.offset = 32'(len);
        2: r.offset = 32'(len - 1);
        default: r.offset = 32'(longint'($urandom) % len);
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  task automatic add_req(op_t o, logic [3:0][15:0] c, logic [31:0] off);
    req_t r;
    r.op = o;
    r.coord = c;
    r.offset = off;
    pending_reqs.push_back(r);
  endtask

  task automatic random_box();
    logic [3:0][15:0] lo, hi;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lo[d] = 16'($urandom);
      case ($urandom_range(0, 4))
        0: hi[d] = lo[d];
        1: hi[d] = ($signed(lo[d]) > 32767 - 300) ? 16'h7FFF : lo[d] + 16'($urandom_range(0, 300));
        2: begin lo[d] = 16'h8000 + 16'($urandom_range(0, 3)); hi[d] = 16'h7FFF; end
        default: hi[d] = ($signed(lo[d]) > 32767 - 7) ? 16'h7FFF : lo[d] + 16'($urandom_range(0, 7));
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      int d = $urandom_range(0, 3);
      lo[d] = 16'h0010;
      hi[d] = 16'h000F;
    end
    set_box(lo, hi);
  endtask

  initial begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      box_lo[d] = '0;
      box_hi[d] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // reset box: single element at origin
    add_req(OP_LEFT_OFFSET, '0, '0);
    add_req(OP_RIGHT_INDEX, '0, '0);
    add_req(OP_LEFT_INDEX, '0, 32'd1);
    add_req(OP_RIGHT_OFFSET, {16'h0, 16'h0, 16'h0, 16'h0001}, '0);
    drain();
    // small box with negative bounds
    set_box({16'hFFFE, 16'h0003, 16'hFFFF, 16'hFFFD}, {16'h0001, 16'h0005, 16'h0002, 16'h0000});
    for (int o = 0; o < 4; o++) begin
      add_req(op_t'(o), {16'hFFFE, 16'h0003, 16'hFFFF, 16'hFFFD}, '0);
      add_req(op_t'(o), {16'h0001, 16'h0005, 16'h0002, 16'h0000}, 32'd191);
      add_req(op_t'(o), {16'h0002, 16'h0005, 16'h0002, 16'h0000}, 32'd192);
    end
    add_req(OP_LEFT_OFFSET, {16'h0, 16'h4, 16'h0, 16'hFFFC}, '0);
    drain();
    // full-range box: length saturates
    set_box({4{16'h8000}}, {4{16'h7FFF}});
    add_req(OP_LEFT_OFFSET, {4{16'h7FFF}}, '0);
    add_req(OP_RIGHT_OFFSET, {16'h8000, 16'h8000, 16'h8001, 16'h8000}, '0);
    add_req(OP_LEFT_OFFSET, {16'h8000, 16'h8000, 16'h8001, 16'hFFFF}, '0);
    add_req(OP_LEFT_INDEX, '0, 32'hFFFF_FFFE);
    add_req(OP_RIGHT_INDEX, '0, 32'hFFFF_FFFF);
    add_req(OP_RIGHT_INDEX, '0, 32'hAAAA_5555);
    drain();
    // upper below lower
    set_box('0, {16'h0, 16'hFFFF, 16'h0, 16'h0});
    for (int o = 0; o < 4; o++) add_req(op_t'(o), {4{16'h8000}}, 32'hFFFF_FFFF);
    drain();
    // random phases; one of them with a long receiver hold and enough
    // transactions to fill the pipeline
    for (int ph = 0; ph < 10; ph++) begin
      random_box();
      if (ph == 3) hold_cycles = 400;
      if (ph == 9) idle_on = 1'b0;
      add_random((ph == 3) ? 200 : 25);
      drain();
    end
    $display("checked %0d transactions over 14 bound settings and all four operations", n_checked);
    $display("status ok %0d, out of range %0d, bad configuration %0d", n_ok, n_range, n_bad);
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("[multidim_offset_index_convert_top] OK");
    else
      $display("[multidim_offset_index_convert_top] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
